// ----- sv/hsmp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsmp_pkg
// Shared types, constants and the speed scaling function of the serial mouse
// packetizer.
// ----------------------------------------------------------------------------
package hsmp_pkg;

    // mouse type codes
    localparam logic [1:0] MT_TWO   = 2'd0;
    localparam logic [1:0] MT_THREE = 2'd1;
    localparam logic [1:0] MT_WHEEL = 2'd2;

    // speed setting codes
    localparam logic [1:0] SPD_FULL = 2'd0;
    localparam logic [1:0] SPD_75   = 2'd1;
    localparam logic [1:0] SPD_50   = 2'd2;
    localparam logic [1:0] SPD_25   = 2'd3;

    // configuration register indexes
    localparam logic REG_MOUSE_TYPE = 1'b0;
    localparam logic REG_SPEED      = 1'b1;

    // input item kinds
    localparam logic MODE_REPORT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // index of the final byte in a short and a long packet
    localparam logic [1:0] LAST_IDX_SHORT = 2'd2;
    localparam logic [1:0] LAST_IDX_LONG  = 2'd3;

    // packet queue geometry
    localparam int          QUEUE_DEPTH = 2;
    localparam logic [1:0]  QUEUE_FULL  = 2'd2;

    typedef struct packed {
        logic [3:0][6:0] data;
        logic            is_long;
    } pkt_t;

    // scale by 1, 3/4, 1/2 or 1/4 per speed setting, truncating toward zero
    function automatic logic signed [7:0] scale_axis(input logic signed [7:0] v,
                                                     input logic [1:0] sp);
        logic signed [9:0] p;
        logic signed [9:0] t;
        logic signed [9:0] adj;
        logic signed [9:0] q;
        p   = {{2{v[7]}}, v};
        t   = p + (p <<< 1);
        adj = 10'sd0;
        q   = p;
        unique case (sp)
            SPD_FULL:
            begin
                q = p;
            end
            SPD_75:
            begin
                adj = t[9] ? 10'sd3 : 10'sd0;
                q   = t + adj;
                q   = q >>> 2;
            end
            SPD_50:
            begin
                adj = p[9] ? 10'sd1 : 10'sd0;
                q   = p + adj;
                q   = q >>> 1;
            end
            SPD_25:
            begin
                adj = p[9] ? 10'sd3 : 10'sd0;
                q   = p + adj;
                q   = q >>> 2;
            end
        endcase
        return q[7:0];
    endfunction

endpackage

// ----- sv/hsmp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsmp_front
// Accepts reports and ticks, keeps button latches and motion accumulators,
// and builds a packet on each tick that sees a change.
// ----------------------------------------------------------------------------
module hsmp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [2:0]          buttons,
    input  logic signed [7:0]   dx,
    input  logic signed [7:0]   dy,
    input  logic signed [7:0]   scroll,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [1:0]          cfg_data,
    input  logic                queue_full,
    output logic                push,
    output hsmp_pkg::pkt_t      push_pkt
);

    logic [1:0]         mouse_type_reg, mouse_type_next;
    logic [1:0]         speed_reg, speed_next;
    logic [2:0]         level_reg, level_next;     // 0 left, 1 middle, 2 right
    logic [2:0]         seen_reg, seen_next;
    logic [2:0]         pending_reg, pending_next;
    logic signed [7:0]  acc_x_reg, acc_x_next;
    logic signed [7:0]  acc_y_reg, acc_y_next;
    logic signed [4:0]  acc_s_reg, acc_s_next;
    logic [2:0]         sent_reg, sent_next;

    logic               accept;
    logic               mid_en;
    logic               wheel_en;
    logic [2:0]         press_vec;
    logic [2:0]         en_vec;
    logic signed [8:0]  sum_x;
    logic signed [8:0]  sum_y;
    logic signed [8:0]  sum_s;
    logic signed [7:0]  x_scaled;
    logic signed [7:0]  y_scaled;
    logic [4:0]         neg_s;
    logic               changed;

    assign in_ready  = !queue_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    assign wheel_en  = (mouse_type_reg == hsmp_pkg::MT_WHEEL);
    assign mid_en    = wheel_en || (mouse_type_reg == hsmp_pkg::MT_THREE);
    assign press_vec = {buttons[1], buttons[2], buttons[0]};
    assign en_vec    = {1'b1, mid_en, 1'b1};

    assign sum_x = {acc_x_reg[7], acc_x_reg} + {dx[7], dx};
    assign sum_y = {acc_y_reg[7], acc_y_reg} + {dy[7], dy};
    assign sum_s = {{4{acc_s_reg[4]}}, acc_s_reg} + {scroll[7], scroll};

    assign x_scaled = hsmp_pkg::scale_axis(acc_x_reg, speed_reg);
    assign y_scaled = hsmp_pkg::scale_axis(acc_y_reg, speed_reg);
    assign neg_s    = 5'd0 - acc_s_reg;

    assign changed = (|seen_reg) || (|(sent_reg & ~level_reg))
                   || (x_scaled != 8'sd0) || (y_scaled != 8'sd0)
                   || (acc_s_reg != 5'sd0);

    // configuration
    always_comb
    begin
        mouse_type_next = mouse_type_reg;
        speed_next      = speed_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hsmp_pkg::REG_MOUSE_TYPE: mouse_type_next = cfg_data;
                hsmp_pkg::REG_SPEED:      speed_next      = cfg_data;
            endcase
        end
    end

    // cycle state
    always_comb
    begin
        level_next   = level_reg;
        seen_next    = seen_reg;
        pending_next = pending_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        acc_s_next   = acc_s_reg;
        sent_next    = sent_reg;
        if (accept && (mode == hsmp_pkg::MODE_REPORT))
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (en_vec[i])
                begin
                    // a press wins, a release inside the cycle is deferred
                    priority if (!seen_reg[i])
                    begin
                        level_next[i] = press_vec[i];
                        seen_next[i]  = 1'b1;
                    end
                    else if (press_vec[i] && !level_reg[i])
                    begin
                        level_next[i] = 1'b1;
                    end
                    else if (!press_vec[i] && level_reg[i])
                    begin
                        pending_next[i] = 1'b1;
                    end
                end
            end
            priority if (sum_x > 9'sd127)
                acc_x_next = 8'sd127;
            else if (sum_x < -9'sd127)
                acc_x_next = -8'sd127;
            else
                acc_x_next = sum_x[7:0];
            priority if (sum_y > 9'sd127)
                acc_y_next = 8'sd127;
            else if (sum_y < -9'sd127)
                acc_y_next = -8'sd127;
            else
                acc_y_next = sum_y[7:0];
            if (wheel_en)
            begin
                priority if (sum_s > 9'sd15)
                    acc_s_next = 5'sd15;
                else if (sum_s < -9'sd15)
                    acc_s_next = -5'sd15;
                else
                    acc_s_next = sum_s[4:0];
            end
        end
        else if (accept && (mode == hsmp_pkg::MODE_TICK))
        begin
            level_next   = level_reg ^ pending_reg;
            seen_next    = pending_reg;
            pending_next = 3'b000;
            acc_x_next   = 8'sd0;
            acc_y_next   = 8'sd0;
            acc_s_next   = 5'sd0;
            sent_next    = level_reg;
        end
    end

    // packet build
    always_comb
    begin
        push             = accept && (mode == hsmp_pkg::MODE_TICK) && changed;
        push_pkt.data[0] = {1'b1, level_reg[0], level_reg[2], y_scaled[7:6], x_scaled[7:6]};
        push_pkt.data[1] = {1'b0, x_scaled[5:0]};
        push_pkt.data[2] = {1'b0, y_scaled[5:0]};
        push_pkt.data[3] = {1'b0, level_reg[1], 1'b0, (wheel_en ? neg_s[3:0] : 4'b0000)};
        push_pkt.is_long = mid_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mouse_type_reg <= hsmp_pkg::MT_TWO;
            speed_reg      <= hsmp_pkg::SPD_FULL;
            level_reg      <= 3'b000;
            seen_reg       <= 3'b000;
            pending_reg    <= 3'b000;
            acc_x_reg      <= 8'sd0;
            acc_y_reg      <= 8'sd0;
            acc_s_reg      <= 5'sd0;
            sent_reg       <= 3'b000;
        end
        else
        begin
            mouse_type_reg <= mouse_type_next;
            speed_reg      <= speed_next;
            level_reg      <= level_next;
            seen_reg       <= seen_next;
            pending_reg    <= pending_next;
            acc_x_reg      <= acc_x_next;
            acc_y_reg      <= acc_y_next;
            acc_s_reg      <= acc_s_next;
            sent_reg       <= sent_next;
        end
    end

endmodule

// ----- sv/hsmp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsmp_queue
// Two-entry packet queue between the packet builder and the byte sender.
// ----------------------------------------------------------------------------
module hsmp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hsmp_pkg::pkt_t  push_pkt,
    output logic            full,
    input  logic            pop,
    output hsmp_pkg::pkt_t  head_pkt,
    output logic            empty
);

    hsmp_pkg::pkt_t mem_reg [hsmp_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full     = (count_reg == hsmp_pkg::QUEUE_FULL);
    assign empty    = (count_reg == 2'd0);
    assign head_pkt = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("packet pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("packet popped from an empty queue");

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with the fill count");
`endif

endmodule

// ----- sv/hsmp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsmp_back
// Sends the queued packets one byte per transaction through an output
// register.
// ----------------------------------------------------------------------------
module hsmp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  hsmp_pkg::pkt_t  head_pkt,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [6:0]      tx_byte,
    output logic            last_byte
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] tx_byte_reg, tx_byte_next;
    logic       last_byte_reg, last_byte_next;
    logic       load;
    logic       is_last;

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign last_byte = last_byte_reg;

    assign load    = !out_valid_reg || out_ready;
    assign is_last = (idx_reg == (head_pkt.is_long ? hsmp_pkg::LAST_IDX_LONG
                                                   : hsmp_pkg::LAST_IDX_SHORT));
    assign pop     = load && !empty && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        tx_byte_next   = tx_byte_reg;
        last_byte_next = last_byte_reg;
        if (load)
        begin
            out_valid_next = !empty;
            tx_byte_next   = head_pkt.data[idx_reg];
            last_byte_next = is_last;
            if (!empty)
            begin
                idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tx_byte_reg   <= tx_byte_next;
        last_byte_reg <= last_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/hid_to_serial_mouse_packetizer.sv -----
`timescale 1ns / 1ps
// first packet byte: the tick's packet is written into the queue, then loaded into the output register
// throughput: one input transaction per cycle while the packet queue has room
// output: one byte per cycle while out_ready is high; a packet has 3 or 4 bytes
// the two-entry packet queue sets how far ticks may run ahead of the sender
// reset: clears latches, accumulators, config registers, queue and output valid
// ----------------------------------------------------------------------------
// hid_to_serial_mouse_packetizer
// Turns mouse reports and transmit ticks into seven-bit serial mouse packets.
// ----------------------------------------------------------------------------
module hid_to_serial_mouse_packetizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [2:0]          buttons,
    input  logic signed [7:0]   dx,
    input  logic signed [7:0]   dy,
    input  logic signed [7:0]   scroll,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [6:0]          tx_byte,
    output logic                last_byte,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [1:0]          cfg_data
);

    logic           queue_full;
    logic           queue_empty;
    logic           push;
    logic           pop;
    hsmp_pkg::pkt_t push_pkt;
    hsmp_pkg::pkt_t head_pkt;

    hsmp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .buttons    (buttons),
        .dx         (dx),
        .dy         (dy),
        .scroll     (scroll),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_pkt   (push_pkt)
    );

    hsmp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .full     (queue_full),
        .pop      (pop),
        .head_pkt (head_pkt),
        .empty    (queue_empty)
    );

    hsmp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_pkt  (head_pkt),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .last_byte (last_byte)
    );

endmodule
